@@ src/assert_macros.svh @@
// Assertion macros shared by the scope trigger capture RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SEC_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");
`else
`define SEC_ASSERT_IMPL(lbl, ant, cons)
`endif

`ifndef SYNTH
`define SEC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");
`else
`define SEC_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

@@ src/sec_pkg.sv @@
// Package for the scope edge trigger capture block.
// Holds payload structs, field widths, codes and the controller state type.
package sec_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int POS_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RISING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEVEL  = 1'b1;

  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 12'd2048;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } sec_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] second_sample;
    logic                trigger_found;
    logic [POS_W-1:0]    trigger_position;
    logic                last;
  } sec_out_t;

  typedef struct packed {
    logic                rising_edge;
    logic [SAMPLE_W-1:0] trigger_level;
  } sec_cfg_t;

  typedef enum logic [2:0] {
    SEC_IDLE,
    SEC_SEARCH,
    SEC_FETCH_A,
    SEC_FETCH_B,
    SEC_LOAD,
    SEC_EMIT
  } sec_state_t;

endpackage

@@ src/scope_edge_trigger_capture_top.sv @@
// Scope edge trigger capture: top level with configuration registers.
// A sample transfer is taken whenever the controller is idle; a capture stalls the input
// through a backward search of up to RING_DEPTH/2 steps and the window readout, plus output stalls.
// The search costs one ring read per step through the single memory read port.
// Reset sets the newest pointer to the last entry and clears the fill count; unwritten entries read as zero.
// Depends on sec_pkg, sec_ring and sec_ctrl.
module scope_edge_trigger_capture_top #(
  parameter int RING_DEPTH = 2048,
  parameter int WINDOW = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  sec_pkg::sec_in_t              in_data,
  output logic                          in_stall,
  output logic                          out_valid,
  output sec_pkg::sec_out_t             out_data,
  input  logic                          out_stall,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sec_pkg::CFG_DAT_W-1:0] cfg_data
);
  import sec_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  logic                rising_r;
  logic [SAMPLE_W-1:0] level_r;
  sec_cfg_t            cfg;
  logic                wr_en;
  logic [SAMPLE_W-1:0] wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       newest;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rising_r <= 1'b1;
      level_r  <= LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_RISING: rising_r <= cfg_data[0];
        CFG_IDX_LEVEL:  level_r  <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.rising_edge   = rising_r;
  assign cfg.trigger_level = level_r;

  sec_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .newest  (newest)
  );

  sec_ctrl #(
    .RING_DEPTH(RING_DEPTH),
    .WINDOW    (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg       (cfg),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .newest    (newest)
  );

endmodule

@@ src/sec_ring.sv @@
// Sample ring memory with newest-index pointer and fill count.
// Entries beyond the fill count read as zero. Depends on sec_pkg.
`include "assert_macros.svh"

module sec_ring #(
  parameter int RING_DEPTH = 2048,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [sec_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [sec_pkg::SAMPLE_W-1:0] rd_data,
  output logic [AW-1:0]                newest
);
  import sec_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   FULL = (AW + 1)'(RING_DEPTH);

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [AW-1:0]       newest_r;
  logic [AW-1:0]       newest_nxt;
  logic [AW:0]         fill_r;
  logic [SAMPLE_W-1:0] q_r;
  logic                hit_r;

  assign newest_nxt = (newest_r == LAST) ? '0 : newest_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= LAST;
      fill_r   <= '0;
    end else if (wr_en) begin
      newest_r <= newest_nxt;
      if (fill_r < FULL) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[newest_nxt] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r   <= mem[rd_addr];
      hit_r <= ({1'b0, rd_addr} < fill_r);
    end
  end

  assign rd_data = hit_r ? q_r : '0;
  assign newest  = newest_r;

  `SEC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FULL)
  `SEC_ASSERT_NEXT(a_newest_wrap, wr_en && (newest_r == LAST), newest_r == '0)
  `SEC_ASSERT_NEXT(a_fill_step, wr_en && (fill_r < FULL), fill_r == $past(fill_r) + 1'b1)

endmodule

@@ src/sec_ctrl.sv @@
// Capture controller: backward edge search and window readout over the ring.
// Drives the ring write and read ports and the result register. Depends on sec_pkg.
`include "assert_macros.svh"

module sec_ctrl #(
  parameter int RING_DEPTH = 2048,
  parameter int WINDOW = 128,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  sec_pkg::sec_in_t             in_data,
  output logic                         in_stall,
  output logic                         out_valid,
  output sec_pkg::sec_out_t            out_data,
  input  logic                         out_stall,
  input  sec_pkg::sec_cfg_t            cfg,
  output logic                         wr_en,
  output logic [sec_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  logic [sec_pkg::SAMPLE_W-1:0] rd_data,
  input  logic [AW-1:0]                newest
);
  import sec_pkg::*;

  localparam int HALF = RING_DEPTH / 2;
  localparam int SW   = $clog2(HALF);
  localparam int HW   = WINDOW / 2;
  localparam int IW   = $clog2(WINDOW + 2);

  localparam logic [AW-1:0] LAST      = AW'(RING_DEPTH - 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(HALF - 1);

  sec_state_t          state_r;
  sec_state_t          state_nxt;
  logic [AW-1:0]       ptr_r;
  logic [AW-1:0]       cand_r;
  logic [AW-1:0]       start_r;
  logic [AW-1:0]       trig_r;
  logic [SW-1:0]       steps_r;
  logic [IW-1:0]       idx_r;
  logic [SAMPLE_W-1:0] cur_r;
  logic [SAMPLE_W-1:0] a_r;
  logic                qv_r;
  logic                have_cur_r;
  logic                found_r;
  logic                out_valid_r;
  sec_out_t            out_r;

  logic          in_xfer;
  logic          capture;
  logic          hit;
  logic          search_cmp;
  logic          search_done;
  logic          pair_last;
  logic [AW-1:0] start_pos;

  function automatic logic [AW-1:0] back1(input logic [AW-1:0] x);
    return (x == '0) ? LAST : x - 1'b1;
  endfunction

  function automatic logic [AW-1:0] fwd1(input logic [AW-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [AW-1:0] back_hw(input logic [AW-1:0] x);
    return (x >= AW'(HW)) ? x - AW'(HW) : x + AW'(RING_DEPTH - HW);
  endfunction

  assign in_xfer   = in_valid && !in_stall;
  assign capture   = in_xfer && (in_data.kind == KIND_CAPTURE);
  assign start_pos = back_hw(newest);
  assign pair_last = ((idx_r + IW'(2)) >= IW'(WINDOW));

  assign hit = cfg.rising_edge ?
               ((cur_r >= cfg.trigger_level) && (rd_data < cfg.trigger_level)) :
               ((cur_r <= cfg.trigger_level) && (rd_data > cfg.trigger_level));
  assign search_cmp  = (state_r == SEC_SEARCH) && qv_r && have_cur_r;
  assign search_done = search_cmp && (hit || (steps_r == STEP_LAST));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEC_IDLE: begin
        if (capture) begin
          state_nxt = SEC_SEARCH;
        end
      end
      SEC_SEARCH: begin
        if (search_done) begin
          state_nxt = SEC_FETCH_A;
        end
      end
      SEC_FETCH_A: state_nxt = SEC_FETCH_B;
      SEC_FETCH_B: state_nxt = SEC_LOAD;
      SEC_LOAD:    state_nxt = SEC_EMIT;
      SEC_EMIT: begin
        if (!out_stall) begin
          state_nxt = pair_last ? SEC_IDLE : SEC_FETCH_A;
        end
      end
      default: state_nxt = SEC_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    case (state_r)
      SEC_IDLE:    in_stall = 1'b0;
      SEC_SEARCH:  rd_en = 1'b1;
      SEC_FETCH_A: rd_en = 1'b1;
      SEC_FETCH_B: rd_en = 1'b1;
      default:     rd_en = 1'b0;
    endcase
  end

  assign rd_addr   = ptr_r;
  assign wr_en     = in_xfer && (in_data.kind == KIND_SAMPLE);
  assign wr_data   = in_data.sample;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == SEC_LOAD) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == SEC_EMIT) && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      SEC_IDLE: begin
        if (capture) begin
          ptr_r      <= start_pos;
          start_r    <= start_pos;
          cand_r     <= start_pos;
          qv_r       <= 1'b0;
          have_cur_r <= 1'b0;
          steps_r    <= '0;
        end
      end
      SEC_SEARCH: begin
        ptr_r <= back1(ptr_r);
        qv_r  <= 1'b1;
        if (qv_r) begin
          if (!have_cur_r) begin
            cur_r      <= rd_data;
            have_cur_r <= 1'b1;
          end else if (hit) begin
            trig_r  <= cand_r;
            found_r <= 1'b1;
            ptr_r   <= back_hw(cand_r);
            idx_r   <= '0;
          end else if (steps_r == STEP_LAST) begin
            trig_r  <= start_r;
            found_r <= 1'b0;
            ptr_r   <= back_hw(start_r);
            idx_r   <= '0;
          end else begin
            cur_r   <= rd_data;
            cand_r  <= back1(cand_r);
            steps_r <= steps_r + 1'b1;
          end
        end
      end
      SEC_FETCH_A: ptr_r <= fwd1(ptr_r);
      SEC_FETCH_B: begin
        a_r   <= rd_data;
        ptr_r <= fwd1(ptr_r);
      end
      SEC_LOAD: begin
        out_r.first_sample     <= a_r;
        out_r.second_sample    <= ((idx_r + IW'(1)) < IW'(WINDOW)) ? rd_data : '0;
        out_r.trigger_found    <= found_r;
        out_r.trigger_position <= POS_W'(trig_r);
        out_r.last             <= pair_last;
      end
      SEC_EMIT: begin
        if (!out_stall) begin
          idx_r <= idx_r + IW'(2);
        end
      end
      default: ;
    endcase
  end

  `SEC_ASSERT_IMPL(a_busy_stall, out_valid_r, in_stall)
  `SEC_ASSERT_IMPL(a_steps_bound, state_r == SEC_SEARCH, steps_r <= STEP_LAST)
  `SEC_ASSERT_NEXT(a_last_idle, out_valid_r && !out_stall && out_r.last, state_r == SEC_IDLE)

endmodule
